### design/open_address_hash_set_macros.svh
// ----------------------------------------------------------------------------
// open_address_hash_set_macros.svh
// Assertion macros used by the top-level hash set design file.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_SET_MACROS_SVH
`define OPEN_ADDRESS_HASH_SET_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define OHS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define OHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Types and fixed constants shared by the hash set controller and datapath.
// ----------------------------------------------------------------------------
package ohs_pkg;

    // Field widths.
    localparam int KEY_W      = 32;
    localparam int STRIDE_W   = 10;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_STRIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MARKER = 1'd1;

    // Register reset values; the marker is a quarter of the largest
    // positive 32-bit signed value.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 10'd1;
    localparam logic [KEY_W-1:0]    MARKER_RESET = 32'd536870911;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_CLEAR
    } ohs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_req;
        logic clr_step;
        logic rd_issue;
        logic probe_init;
        logic probe_adv;
        logic ins_write;
        logic resp_valid;
        logic resp_found;
        logic resp_status;
    } ohs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_busy;
        logic op_clear;
        logic op_probe;
        logic op_insert;
        logic slot_empty;
        logic slot_hit;
        logic count_last;
        logic clr_last;
    } ohs_sts_t;

endpackage

### design/ohs_ram.sv
// ----------------------------------------------------------------------------
// ohs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ohs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ohs_mod.sv
// ----------------------------------------------------------------------------
// ohs_mod
// Remainder of a value by the table depth. A power-of-two depth registers
// the low bits; any other depth registers a reciprocal multiply, then the
// difference, then the result of one correction step.
// ----------------------------------------------------------------------------
module ohs_mod #(
    parameter int IN_W  = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [IN_W-1:0]          value,
    output logic                     busy,
    output logic [$clog2(DEPTH)-1:0] rem
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    logic [IDX_W-1:0] rem_reg;

    generate
        if (IS_POW2)
        begin : g_mask
            localparam int EXT_W = (IN_W > IDX_W) ? IN_W : IDX_W;

            logic [EXT_W-1:0] value_ext;

            assign value_ext = EXT_W'(value);

            // The low bits are the remainder.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rem_reg <= '0;
                end
                else if (start)
                begin
                    rem_reg <= value_ext[IDX_W-1:0];
                end
            end

            assign busy = 1'b0;
        end
        else
        begin : g_recip
            localparam int M_W   = IN_W + 1;
            localparam int P_W   = IN_W + M_W;
            localparam int SHIFT = IN_W + IDX_W;
            localparam int E_W   = (IN_W > IDX_W) ? IN_W : IDX_W + 1;
            localparam logic [M_W-1:0] RECIP_C = M_W'((64'd1 << SHIFT) / 64'(DEPTH));
            localparam logic [E_W-1:0] DEPTH_C = E_W'(DEPTH);

            logic [1:0]      stage_reg;
            logic [IN_W-1:0] val_reg;
            logic [P_W-1:0]  prod_reg;
            logic [E_W-1:0]  diff_reg;
            logic [P_W-1:0]  prod;
            logic [P_W-1:0]  quot_full;
            logic [E_W-1:0]  quot;
            logic [E_W-1:0]  diff;
            logic [E_W-1:0]  diff_sub;

            // The scaled reciprocal gives the quotient or one less, so the
            // first difference lies below twice the depth.
            assign prod      = P_W'(value) * P_W'(RECIP_C);
            assign quot_full = prod_reg >> SHIFT;
            assign quot      = E_W'(quot_full);
            assign diff      = E_W'(val_reg) - quot * DEPTH_C;
            assign diff_sub  = diff_reg - DEPTH_C;

            // Stage tracking: a single set bit marks the step to run next.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                end
                else if (start)
                begin
                    stage_reg <= 2'b01;
                end
                else
                begin
                    stage_reg <= {stage_reg[0], 1'b0};
                end
            end

            // Product, difference and final correction.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg  <= value;
                    prod_reg <= prod;
                end
                if (stage_reg[0])
                begin
                    diff_reg <= diff;
                end
                if (stage_reg[1])
                begin
                    if (diff_reg >= DEPTH_C)
                    begin
                        rem_reg <= diff_sub[IDX_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= diff_reg[IDX_W-1:0];
                    end
                end
            end

            assign busy = |stage_reg;
        end
    endgenerate

    assign rem = rem_reg;

endmodule

### design/ohs_datapath.sv
// ----------------------------------------------------------------------------
// ohs_datapath
// Request registers, configuration registers, slot memory, probe address
// arithmetic and result registers of the hash set.
// ----------------------------------------------------------------------------
module ohs_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ohs_pkg::ohs_cmd_t               cmd,
    output ohs_pkg::ohs_sts_t               sts,
    input  logic [ohs_pkg::MODE_W-1:0]      mode,
    input  logic [ohs_pkg::KEY_W-1:0]       key,
    input  logic                            cfg_we,
    input  logic [ohs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ohs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            done,
    output logic                            found,
    output logic                            status
);

    import ohs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int RAM_W = KEY_W + 1;
    localparam logic [IDX_W:0]   DEPTH_C = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(DEPTH - 1);

    logic [STRIDE_W-1:0] stride_reg;
    logic [KEY_W-1:0]    marker_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    count_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic                done_reg;
    logic                found_reg;
    logic                status_reg;

    logic [IDX_W-1:0]    key_rem;
    logic [IDX_W-1:0]    stride_rem;
    logic                key_busy;
    logic                stride_busy;
    logic [IDX_W:0]      slot_sum;
    logic [IDX_W:0]      slot_wrap;
    logic [IDX_W-1:0]    slot_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            marker_reg <= MARKER_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PROBE_STRIDE)
            begin
                stride_reg <= cfg_data[STRIDE_W-1:0];
            end
            if (cfg_index == REG_EMPTY_MARKER)
            begin
                marker_reg <= cfg_data[KEY_W-1:0];
            end
        end
    end

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            mode_reg <= mode;
            key_reg  <= key;
        end
    end

    // Home slot and effective stride, both reduced by the table depth.
    ohs_mod #(
        .IN_W  (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.latch_req),
        .value (key),
        .busy  (key_busy),
        .rem   (key_rem)
    );

    ohs_mod #(
        .IN_W  (STRIDE_W),
        .DEPTH (DEPTH)
    ) u_stride_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.latch_req),
        .value (stride_reg),
        .busy  (stride_busy),
        .rem   (stride_rem)
    );

    // Next probe slot: both terms are below the depth, so one subtract wraps it.
    assign slot_sum  = {1'b0, slot_reg} + {1'b0, stride_rem};
    assign slot_wrap = slot_sum - DEPTH_C;
    assign slot_next = (slot_sum >= DEPTH_C) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];

    // Probe slot and probe count.
    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            slot_reg  <= key_rem;
            count_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            slot_reg  <= slot_next;
            count_reg <= count_reg + IDX_W'(1);
        end
    end

    // Sweep address for clearing the used bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            if (clr_addr_reg == LAST_C)
            begin
                clr_addr_reg <= '0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
        end
    end

    // Slot memory: each word holds the used bit above the key.
    assign ram_we    = cmd.clr_step | cmd.ins_write;
    assign ram_waddr = cmd.clr_step ? clr_addr_reg : slot_reg;
    assign ram_wdata = cmd.clr_step ? '0 : {1'b1, key_reg};

    ohs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Status toward the controller.
    always_comb
    begin
        sts            = '0;
        sts.mod_busy   = key_busy | stride_busy;
        sts.op_clear   = (mode_reg == MODE_CLEAR);
        sts.op_insert  = (mode_reg == MODE_INSERT);
        sts.op_probe   = ((mode_reg == MODE_LOOKUP) || (mode_reg == MODE_INSERT))
                         && (key_reg != marker_reg);
        sts.slot_empty = !ram_rdata[KEY_W];
        sts.slot_hit   = ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == key_reg);
        sts.count_last = (count_reg == LAST_C);
        sts.clr_last   = (clr_addr_reg == LAST_C);
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.resp_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.resp_valid)
        begin
            found_reg  <= cmd.resp_found;
            status_reg <= cmd.resp_status;
        end
    end

    assign done   = done_reg;
    assign found  = found_reg;
    assign status = status_reg;

endmodule

### design/ohs_ctrl.sv
// ----------------------------------------------------------------------------
// ohs_ctrl
// Controller of the hash set: clearing sweeps, request dispatch and the
// probe loop over the slot memory.
// ----------------------------------------------------------------------------
module ohs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ohs_pkg::ohs_sts_t sts,
    output ohs_pkg::ohs_cmd_t cmd
);

    import ohs_pkg::*;

    ohs_state_t state_reg;
    ohs_state_t state_next;

    // State register; reset starts the sweep that empties the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.op_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (sts.op_probe)
                begin
                    state_next = sts.mod_busy ? ST_HASH : ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HASH:
            begin
                if (!sts.mod_busy)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.slot_hit || sts.slot_empty || sts.count_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.latch_req = start;
            end
            ST_DISPATCH:
            begin
                if (sts.op_clear)
                begin
                    cmd = '0;
                end
                else if (sts.op_probe)
                begin
                    cmd.probe_init = !sts.mod_busy;
                end
                else
                begin
                    // Marker key or unused mode: answer at once.
                    cmd.resp_valid = 1'b1;
                end
            end
            ST_HASH:
            begin
                cmd.probe_init = !sts.mod_busy;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_CHECK:
            begin
                if (sts.slot_hit)
                begin
                    cmd.resp_valid = 1'b1;
                    cmd.resp_found = 1'b1;
                end
                else if (sts.slot_empty)
                begin
                    cmd.resp_valid = 1'b1;
                    cmd.ins_write  = sts.op_insert;
                end
                else if (sts.count_last)
                begin
                    // Whole chain walked without a hit or a free slot.
                    cmd.resp_valid  = 1'b1;
                    cmd.resp_status = 1'b1;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step   = 1'b1;
                cmd.resp_valid = sts.clr_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### design/open_address_hash_set.sv
// ----------------------------------------------------------------------------
// open_address_hash_set
// Hash set of 32-bit keys with open addressing and a configurable probe
// stride. Each request is a lookup, an insert or a clear of the table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on found and status for a single cycle with done, and must be
// taken then. Each probe of a lookup or insert is one read of the
// registered-read slot memory followed by a compare. With a table depth
// that is not a power of two the home slot comes from a reciprocal
// multiply remainder unit, and the controller waits while it is busy.
// A lookup or insert of a key equal to the empty marker, or an unused
// mode, is answered from the dispatch state without a probe. A clear,
// and the sweep after reset during which busy stays high, walks the slot
// memory at one slot per cycle. Configuration writes are taken at any
// clock edge and belong between requests, while busy is low.
// ----------------------------------------------------------------------------
module open_address_hash_set #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ohs_pkg::MODE_W-1:0]      mode,
    input  logic [ohs_pkg::KEY_W-1:0]       key,
    output logic                            done,
    output logic                            found,
    output logic                            status,
    input  logic                            cfg_we,
    input  logic [ohs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ohs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ohs_pkg::*;

    ohs_cmd_t cmd;
    ohs_sts_t sts;

    // Controller.
    ohs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath with the slot memory.
    ohs_datapath #(
        .DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .key       (key),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .found     (found),
        .status    (status)
    );

    // Checks on request and result sequencing.
`include "open_address_hash_set_macros.svh"

    `OHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `OHS_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
    `OHS_ASSERT_SAME(a_done_after_work, done, $past(busy), "result without a request in work")
    `OHS_ASSERT_SAME(a_found_full, done, !(found && status), "found and full reported together")

endmodule

### bench/open_address_hash_set_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_address_hash_set_test
// Self-checking bench for the open-addressing hash set. A short table of
// hand-picked requests runs first. Random phases follow, each under its own
// probe stride and empty marker, and then a pass that fills every slot.
// Each request is predicted by a shadow copy of the slot table or pinned by
// its row; each done strobe is compared field by field with the oldest answer.
// ----------------------------------------------------------------------------
module open_address_hash_set_test;
    import ohs_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES = 8;

    // One row of the hand-written stimulus; pinned rows carry their answer.
    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        bit                pinned;
        bit                want_found;
        bit                want_status;
    } probe_row_t;

    // One expected answer, with the request that produced it.
    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        bit                found;
        bit                status;
    } answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     mode;
    logic [KEY_W-1:0]      key;
    logic                  done;
    logic                  found;
    logic                  status;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Pinned answer travels alongside the request it belongs to.
    bit pin_valid;
    bit pin_found;
    bit pin_status;

    // Shadow of the slot table and the two registers.
    logic [KEY_W-1:0]    shadow_keys [DEPTH];
    bit                  shadow_used [DEPTH];
    logic [STRIDE_W-1:0] shadow_stride = STRIDE_RESET;
    logic [KEY_W-1:0]    shadow_marker = MARKER_RESET;

    answer_t          answer_q[$];
    logic [KEY_W-1:0] inserted_keys[$];
    int               window_base;
    int               burst_left;
    int               errors;
    int               requests_taken;
    int               hits_seen;
    int               exhausted_seen;
    int               clears_seen;
    int               reg_writes;

    // Hand-written requests, issued under the reset register values.
    probe_row_t probe_rows[23] = '{
        '{MODE_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
        '{MODE_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
        '{MODE_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
        '{MODE_INSERT, 32'h0000_0400, 1'b0, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h0000_0800, 1'b0, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'h0000_0800, 1'b0, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'h0000_0C00, 1'b0, 1'b0, 1'b0},
        '{MODE_INSERT, MARKER_RESET,  1'b1, 1'b0, 1'b0},
        '{MODE_LOOKUP, MARKER_RESET,  1'b1, 1'b0, 1'b0},
        '{MODE_UNUSED, 32'h0000_0005, 1'b1, 1'b0, 1'b0},
        '{MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
        '{MODE_INSERT, 32'h5555_5555, 1'b0, 1'b0, 1'b0},
        '{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
        '{MODE_CLEAR,  32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{MODE_INSERT, 32'd3001,      1'b0, 1'b0, 1'b0},
        '{MODE_LOOKUP, 32'd3001,      1'b1, 1'b1, 1'b0}
    };

    // Stride and request count of each random phase.
    int unsigned phase_stride[PHASES] = '{1, 1023, 3, 512, 0, 2, 777, 1};
    int          phase_items[PHASES]  = '{35, 30, 30, 25, 25, 30, 30, 35};

    open_address_hash_set #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .key       (key),
        .done      (done),
        .found     (found),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow table and return its answer.
    function automatic answer_t predict_answer(input logic [MODE_W-1:0] op,
                                               input logic [KEY_W-1:0] k);
        answer_t     a;
        int unsigned slot;
        int unsigned step;
        int          n;
        bit          settled;
        a.op     = op;
        a.k      = k;
        a.found  = 1'b0;
        a.status = 1'b0;
        if (op == MODE_CLEAR)
        begin
            foreach (shadow_used[i])
                shadow_used[i] = 1'b0;
        end
        else if ((op == MODE_LOOKUP || op == MODE_INSERT) && k != shadow_marker)
        begin
            slot    = k % DEPTH;
            step    = shadow_stride % DEPTH;
            settled = 1'b0;
            // Walk the chain until the key or a free slot turns up.
            for (n = 0; n < DEPTH && !settled; n++)
            begin
                if (!shadow_used[slot])
                begin
                    settled = 1'b1;
                    if (op == MODE_INSERT)
                    begin
                        shadow_keys[slot] = k;
                        shadow_used[slot] = 1'b1;
                    end
                end
                else if (shadow_keys[slot] == k)
                begin
                    settled = 1'b1;
                    a.found = 1'b1;
                end
                else
                begin
                    slot = (slot + step) % DEPTH;
                end
            end
            a.status = !settled;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("open_address_hash_set_test: mismatch at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Check each done strobe, then record any request taken at this edge.
    always @(posedge clk)
    begin
        answer_t want;
        answer_t taken;
        if (rst_n)
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request pending: found %0b status %0b",
                                              found, status));
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("mode %0d key %h: found %b, expected %0b",
                                                  want.op, want.k, found, want.found));
                    if (status !== want.status)
                        report_mismatch($sformatf("mode %0d key %h: status %b, expected %0b",
                                                  want.op, want.k, status, want.status));
                end
            end
            if (start && !busy)
            begin
                taken = predict_answer(mode, key);
                requests_taken++;
                if (taken.found)
                    hits_seen++;
                if (taken.status)
                    exhausted_seen++;
                if (mode == MODE_CLEAR)
                    clears_seen++;
                if (pin_valid)
                begin
                    taken.found  = pin_found;
                    taken.status = pin_status;
                end
                answer_q.push_back(taken);
            end
        end
    end

    // Present one request and hold it until taken; then maybe pause.
    task automatic send_request(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                                input bit pinned, input bit pf, input bit ps);
        start      <= 1'b1;
        mode       <= op;
        key        <= k;
        pin_valid  <= pinned;
        pin_found  <= pf;
        pin_status <= ps;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Stop sending and let every outstanding answer arrive.
    task automatic wait_quiet();
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PROBE_STRIDE)
            shadow_stride = data[STRIDE_W-1:0];
        else
            shadow_marker = data[KEY_W-1:0];
        reg_writes++;
        @(negedge clk);
    endtask

    // Keys: earlier inserts, clusters around a few home slots, wide random
    // values, the current marker and a handful of extremes.
    function automatic logic [KEY_W-1:0] pick_key();
        int               sel;
        logic [KEY_W-1:0] hi;
        logic [9:0]       home;
        sel  = $urandom_range(0, 99);
        hi   = $urandom;
        home = 10'((window_base + $urandom_range(0, 7)) % DEPTH);
        if (sel < 30 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else if (sel < 65)
            return {hi[21:0], home};
        else if (sel < 85)
            return hi;
        else if (sel < 90)
            return shadow_marker;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd3001;
            default: return MARKER_RESET;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 46)
            return MODE_LOOKUP;
        else if (sel < 92)
            return MODE_INSERT;
        else if (sel < 96)
            return MODE_CLEAR;
        return MODE_UNUSED;
    endfunction

    // Stimulus.
    initial
    begin
        probe_row_t        row;
        int                p;
        int                n;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        logic [KEY_W-1:0]  hi;
        logic [KEY_W-1:0]  marker;
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = MODE_LOOKUP;
        key        = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PROBE_STRIDE;
        cfg_data   = '0;
        pin_valid  = 1'b0;
        pin_found  = 1'b0;
        pin_status = 1'b0;
        burst_left = 0;
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Hand-written requests under the reset registers.
        foreach (probe_rows[r])
        begin
            row = probe_rows[r];
            send_request(row.op, row.k, row.pinned, row.want_found, row.want_status);
        end
        wait_quiet();

        // Random phases, each with its own stride and marker.
        for (p = 0; p < PHASES; p++)
        begin
            hi = $urandom;
            write_reg(REG_PROBE_STRIDE, {hi[31:STRIDE_W], STRIDE_W'(phase_stride[p])});
            case (p % 4)
                0: marker = 32'h0000_0000;
                1: marker = 32'hFFFF_FFFF;
                2: marker = $urandom;
                default:
                    marker = (inserted_keys.size() > 0) ? inserted_keys[$] : $urandom;
            endcase
            write_reg(REG_EMPTY_MARKER, marker);
            window_base = $urandom_range(0, DEPTH - 1);
            for (n = 0; n < phase_items[p]; n++)
            begin
                op = pick_mode();
                k  = pick_key();
                if (op == MODE_INSERT && k != shadow_marker)
                begin
                    inserted_keys.push_back(k);
                    if (inserted_keys.size() > 48)
                        void'(inserted_keys.pop_front());
                end
                send_request(op, k, 1'b0, 1'b0, 1'b0);
                if ($urandom_range(0, 149) == 0)
                    wait_quiet();
                if ($urandom_range(0, 39) == 0)
                    window_base = $urandom_range(0, DEPTH - 1);
            end
            wait_quiet();
        end

        // Fill every slot at its home, then probe the full table.
        write_reg(REG_PROBE_STRIDE, STRIDE_RESET);
        write_reg(REG_EMPTY_MARKER, MARKER_RESET);
        send_request(MODE_CLEAR, $urandom, 1'b0, 1'b0, 1'b0);
        for (n = 0; n < DEPTH; n++)
        begin
            hi = $urandom;
            k  = {hi[21:0], 10'(n)};
            if (k == shadow_marker)
                k[31] = ~k[31];
            send_request(MODE_INSERT, k, 1'b0, 1'b0, 1'b0);
        end
        for (n = 0; n < 12; n++)
        begin
            case (n % 3)
                0: send_request(MODE_LOOKUP, $urandom, 1'b0, 1'b0, 1'b0);
                1: send_request(MODE_INSERT, $urandom, 1'b0, 1'b0, 1'b0);
                default: send_request(MODE_LOOKUP, k, 1'b0, 1'b0, 1'b0);
            endcase
        end
        send_request(MODE_CLEAR, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        wait_quiet();
        repeat (8) @(negedge clk);

        $display("open_address_hash_set_test: %0d requests, %0d hits, %0d exhausted chains,",
                 requests_taken, hits_seen, exhausted_seen);
        $display("open_address_hash_set_test: %0d clears, %0d register writes, one full table",
                 clears_seen, reg_writes);
        if (errors == 0)
            $display("open_address_hash_set_test: done, clean");
        else
            $display("open_address_hash_set_test: done, errors");
        $finish;
    end

    // Watchdog: the slowest legal run, every request walking a whole
    // exhausted chain after the longest gap, is about 11 ms.
    initial
    begin
        #100_000_000;
        $display("open_address_hash_set_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/ohs_pkg.sv
design/ohs_ram.sv
design/ohs_mod.sv
design/ohs_datapath.sv
design/ohs_ctrl.sv
design/open_address_hash_set.sv
bench/open_address_hash_set_test.sv
